FILE: rtl/fisher_yates_shuffle_engine_assert.svh
// Assertion macros for the shuffle engine.
// Included by RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef FISHER_YATES_SHUFFLE_ENGINE_ASSERT_SVH
`define FISHER_YATES_SHUFFLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FYSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FYSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fyse_pkg.sv
// Shared types, constants and the microcode table of the shuffle engine.
// No dependencies; imported by the interfaces, the engine and the testbench.
`timescale 1ns / 1ps

package fyse_pkg;

  // Store geometry.
  localparam int unsigned MaxElements = 128;
  localparam int unsigned AddrW       = $clog2(MaxElements);
  localparam int unsigned DataW       = 8;

  // 48-bit generator constants; the multiplier is split at bit 32.
  localparam int unsigned GenW     = 48;
  localparam logic [31:0] GenMulLo = 32'hDEEC_E66D;
  localparam logic [2:0]  GenMulHi = 3'h5;
  localparam logic [47:0] GenAdd   = 48'hB;
  localparam logic [15:0] GenLow   = 16'h330E;

  // Command opcodes.
  typedef enum logic [1:0] {
    OpWrite   = 2'd0,
    OpShuffle = 2'd1,
    OpRead    = 2'd2
  } opcode_e;

  // Status codes.
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  // Microcode fields.
  typedef enum logic [1:0] {
    RdNone,
    RdI,
    RdJ
  } rd_sel_e;

  typedef enum logic [1:0] {
    WrNone,
    WrI,
    WrJ
  } wr_sel_e;

  typedef enum logic [1:0] {
    JNext,
    JDispatch,
    JLoop,
    JResp
  } jump_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    mul_lo;
    logic    mul_hi;
    logic    gen_add;
    logic    scale;
    wr_sel_e wr_sel;
    logic    dec_i;
    jump_e   jump;
  } ucode_t;

  // Step addresses of the microprogram.
  localparam int unsigned UpcW = 4;
  localparam logic [UpcW-1:0] UpIdle  = 4'd0;
  localparam logic [UpcW-1:0] UpMulLo = 4'd1;
  localparam logic [UpcW-1:0] UpMulHi = 4'd2;
  localparam logic [UpcW-1:0] UpAdd   = 4'd3;
  localparam logic [UpcW-1:0] UpScale = 4'd4;
  localparam logic [UpcW-1:0] UpRdJ   = 4'd5;
  localparam logic [UpcW-1:0] UpWrI   = 4'd6;
  localparam logic [UpcW-1:0] UpWrJ   = 4'd7;
  localparam logic [UpcW-1:0] UpResp  = 4'd8;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(logic [UpcW-1:0] upc);
    ucode_t w;
    w = '{rd_sel: RdNone, cap_a: 1'b0, mul_lo: 1'b0, mul_hi: 1'b0, gen_add: 1'b0,
          scale: 1'b0, wr_sel: WrNone, dec_i: 1'b0, jump: JNext};
    case (upc)
      UpIdle:  w.jump = JDispatch;
      UpMulLo: begin
        w.rd_sel = RdI;
        w.mul_lo = 1'b1;
      end
      UpMulHi: begin
        w.cap_a  = 1'b1;
        w.mul_hi = 1'b1;
      end
      UpAdd:   w.gen_add = 1'b1;
      UpScale: w.scale = 1'b1;
      UpRdJ:   w.rd_sel = RdJ;
      UpWrI:   w.wr_sel = WrI;
      UpWrJ:   begin
        w.wr_sel = WrJ;
        w.dec_i  = 1'b1;
        w.jump   = JLoop;
      end
      UpResp:  w.jump = JResp;
      default: w.jump = JResp;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/fyse_if.sv
// Command and response channel interfaces of the shuffle engine.
// Depends on fyse_pkg for field widths.
`timescale 1ns / 1ps

// Command channel: one beat carries one command.
interface fyse_cmd_if;
  import fyse_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [6:0]       index;
  logic [DataW-1:0] value;
  logic [7:0]       count;
  logic [31:0]      seed;

  modport source (output valid, opcode, index, value, count, seed, input ready);
  modport sink (input valid, opcode, index, value, count, seed, output ready);
endinterface

// Response channel: one beat per command.
interface fyse_rsp_if;
  import fyse_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;
  logic             status;

  modport source (output valid, data, status, input ready);
  modport sink (input valid, data, status, output ready);
endinterface

FILE: rtl/fisher_yates_shuffle_engine.sv
// Fisher-Yates shuffle engine: one command beat in, one response beat out. Write and read
// commands are issued on acceptance and then respond. A shuffle of count n (n >= 2) makes
// n-1 swaps: each swap needs the three-step 48-bit generator update (split multiply, high
// partial product, add), one scaling multiply and four accesses to the single read and
// single write port of the element RAM, sequenced by a microcode table. Counts of 0 or 1 and
// all out-of-range commands go straight to the response. A new command is taken once the
// previous one has placed its response in the output register, even if that response has
// not yet been consumed. Elements must be written before read.
// Depends on fyse_pkg, fyse_if, fyse_ram and fisher_yates_shuffle_engine_assert.svh.
`timescale 1ns / 1ps
`include "fisher_yates_shuffle_engine_assert.svh"

module fisher_yates_shuffle_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  fyse_cmd_if.sink   cmd_i,
  fyse_rsp_if.source rsp_o
);
  import fyse_pkg::*;

  // Sequencer state.
  logic [UpcW-1:0] upc_q, upc_d;
  ucode_t          uc;

  // Datapath registers.
  logic [GenW-1:0]  gen_q, gen_d;
  logic [GenW-1:0]  prod_q;
  logic [15:0]      hi_q;
  logic [AddrW-1:0] i_q, j_q;
  logic [DataW-1:0] a_q;
  logic             res_err_q, res_read_q;

  // Output register.
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic             out_status_q;

  // RAM port signals.
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  // Command decode.
  logic             cmd_fire;
  logic             idx_ok, cnt_ok;
  logic [AddrW-1:0] cmd_addr;
  logic             out_free;
  logic             load_cmd;

  // Arithmetic.
  logic [63:0]            mul_lo_full;
  logic [31:0]            mul_hi_a, mul_hi_b;
  logic [AddrW:0]         i_plus1;
  logic [GenW+AddrW:0]    scale_full;
  logic [AddrW:0]         j_raw;

  assign uc        = ucode_rom(upc_q);
  assign cmd_i.ready = (upc_q == UpIdle);
  assign cmd_fire  = cmd_i.valid && cmd_i.ready;
  assign idx_ok    = (32'(cmd_i.index) < MaxElements);
  assign cnt_ok    = (32'(cmd_i.count) <= MaxElements);
  assign cmd_addr  = AddrW'(cmd_i.index);
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign load_cmd  = cmd_fire && (cmd_i.opcode == OpShuffle) && cnt_ok;

  // Next step.
  always_comb begin
    upc_d = upc_q;
    case (uc.jump)
      JNext: upc_d = upc_q + UpcW'(1);
      JDispatch: begin
        if (cmd_fire) begin
          if (load_cmd && (cmd_i.count > 8'd1)) begin
            upc_d = UpMulLo;
          end else begin
            upc_d = UpResp;
          end
        end
      end
      JLoop: upc_d = (i_q > AddrW'(1)) ? UpMulLo : UpResp;
      JResp: begin
        if (out_free) begin
          upc_d = UpIdle;
        end
      end
      default: upc_d = UpIdle;
    endcase
  end

  // Generator arithmetic: low product, high partial products, scaling.
  assign mul_lo_full = {32'd0, gen_q[31:0]} * {32'd0, GenMulLo};
  assign mul_hi_a    = {16'd0, gen_q[47:32]} * {16'd0, GenMulLo[15:0]};
  assign mul_hi_b    = {16'd0, gen_q[15:0]} * {29'd0, GenMulHi};
  assign i_plus1     = {1'b0, i_q} + (AddrW + 1)'(1);
  assign scale_full  = (GenW + AddrW + 1)'(gen_q) * (GenW + AddrW + 1)'(i_plus1);
  assign j_raw       = scale_full[GenW +: AddrW + 1];

  always_comb begin
    gen_d = gen_q;
    if (load_cmd) begin
      gen_d = {cmd_i.seed, GenLow};
    end else if (uc.gen_add) begin
      gen_d = prod_q + {hi_q, 32'd0} + GenAdd;
    end
  end

  // RAM port steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = i_q;
    if (cmd_fire && idx_ok && (cmd_i.opcode == OpWrite)) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_addr;
      ram_wdata = cmd_i.value;
    end
    if (cmd_fire && idx_ok && (cmd_i.opcode == OpRead)) begin
      ram_re    = 1'b1;
      ram_raddr = cmd_addr;
    end
    case (uc.rd_sel)
      RdI: begin
        ram_re    = 1'b1;
        ram_raddr = i_q;
      end
      RdJ: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
      end
      default: ;
    endcase
    case (uc.wr_sel)
      WrI: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      WrJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
      end
      default: ;
    endcase
  end

  fyse_ram #(
    .Width(DataW),
    .Depth(MaxElements)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UpIdle;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      gen_q <= gen_d;
      if ((uc.jump == JResp) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and response payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      res_read_q <= (cmd_i.opcode == OpRead);
      case (cmd_i.opcode)
        OpWrite, OpRead: res_err_q <= !idx_ok;
        OpShuffle:       res_err_q <= !cnt_ok;
        default:         res_err_q <= 1'b0;
      endcase
    end
    if (load_cmd) begin
      i_q <= AddrW'(cmd_i.count - 8'd1);
    end else if (uc.dec_i) begin
      i_q <= i_q - AddrW'(1);
    end
    if (uc.mul_lo) begin
      prod_q <= mul_lo_full[GenW-1:0];
    end
    if (uc.mul_hi) begin
      hi_q <= mul_hi_a[15:0] + mul_hi_b[15:0];
    end
    if (uc.cap_a) begin
      a_q <= ram_rdata;
    end
    if (uc.scale) begin
      j_q <= (j_raw > {1'b0, i_q}) ? i_q : j_raw[AddrW-1:0];
    end
    if ((uc.jump == JResp) && out_free) begin
      out_data_q   <= (res_read_q && !res_err_q) ? ram_rdata : '0;
      out_status_q <= res_err_q ? StatusErr : StatusOk;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.data   = out_data_q;
  assign rsp_o.status = out_status_q;

  // Checks on the sequencer.
  `FYSE_ASSERT_NEXT(a_cmd_runs_program, cmd_fire, upc_q != UpIdle, "command did not start")
  `FYSE_ASSERT_NOW(a_loop_index_live, upc_q == UpMulLo, i_q != '0, "swap loop at index 0")
  `FYSE_ASSERT_NOW(a_swap_partner_le, upc_q == UpRdJ, j_q <= i_q, "swap partner above loop index")
  `FYSE_ASSERT_NOW(a_rsp_from_resp, $rose(out_valid_q), $past(upc_q) == UpResp, "stray response")

endmodule

FILE: rtl/fyse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module fyse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: dv/fisher_yates_shuffle_engine_tb.sv
// Self-checking testbench of the Fisher-Yates shuffle engine: write, read and seeded shuffle commands.
// Uses fyse_pkg and the fyse_cmd_if / fyse_rsp_if channel interfaces from the RTL.
`timescale 1ns / 1ps

module fisher_yates_shuffle_engine_tb;
  import fyse_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned PhaseItems  = 500;
  localparam int unsigned TailCycles  = 900;
  localparam int unsigned LimitCycles = 2_000_000;

  // Opcode 3 has no enum member; the block treats it as a no-op.
  localparam logic [1:0]  OpUnused = 2'd3;

  // drand48 recurrence constants.
  localparam logic [47:0] LcgMul  = 48'h5_DEEC_E66D;
  localparam logic [47:0] LcgInc  = 48'hB;
  localparam logic [15:0] LcgLow  = 16'h330E;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             status;
  } rsp_beat_t;

  // Mirror of the element store and the generator. Expected responses are queued
  // per accepted command beat and compared in order with response beats.
  class shuffle_tracker;
    logic [DataW-1:0] elems[MaxElements];
    bit               written[MaxElements];
    logic [47:0]      lcg;
    rsp_beat_t        expected_q[$];
    int               errors;

    function new();
      lcg    = '0;
      errors = 0;
      foreach (elems[k]) begin
        elems[k]   = '0;
        written[k] = 1'b0;
      end
    endfunction

    function void apply_command(logic [1:0] op, logic [6:0] idx, logic [DataW-1:0] val,
                                logic [7:0] cnt, logic [31:0] sd);
      rsp_beat_t        r;
      logic [63:0]      prod;
      int               j;
      logic [DataW-1:0] tmp_e;
      bit               tmp_w;
      r.data   = '0;
      r.status = StatusOk;
      case (op)
        OpWrite: begin
          if (idx < MaxElements) begin
            elems[idx]   = val;
            written[idx] = 1'b1;
          end else begin
            r.status = StatusErr;
          end
        end
        OpShuffle: begin
          if (cnt > MaxElements) begin
            r.status = StatusErr;
          end else begin
            // Seeding happens even when the count is too short to swap anything.
            lcg = {sd, LcgLow};
            for (int i = int'(cnt) - 1; i > 0; i--) begin
              lcg  = lcg * LcgMul + LcgInc;
              prod = 64'(lcg) * 64'(i + 1);
              j    = int'(prod[63:48]);
              if (j > i) j = i;
              tmp_e      = elems[j];
              elems[j]   = elems[i];
              elems[i]   = tmp_e;
              tmp_w      = written[j];
              written[j] = written[i];
              written[i] = tmp_w;
            end
          end
        end
        OpRead: begin
          if (idx < MaxElements) r.data = elems[idx];
          else r.status = StatusErr;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void compare_response(logic [DataW-1:0] data, logic status);
      rsp_beat_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response beat data=%02h status=%0b", $time, data, status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: data mismatch: expected %02h, actual %02h", $time, e.data, data);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0b, actual %0b", $time, e.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Random index that holds a written value, or -1 while nothing is written.
    function int pick_written();
      int start;
      start = $urandom_range(0, MaxElements - 1);
      for (int k = 0; k < MaxElements; k++) begin
        if (written[(start + k) % MaxElements]) return (start + k) % MaxElements;
      end
      return -1;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fyse_cmd_if cmd_if ();
  fyse_rsp_if rsp_if ();

  fisher_yates_shuffle_engine u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  shuffle_tracker tracker;
  int unsigned    src_idle_pct;
  int unsigned    dst_stall_pct;
  int unsigned    items_sent;
  int unsigned    cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Receiver: ready is redrawn at every falling edge.
  initial rsp_if.ready = 1'b0;
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= dst_stall_pct);
  end

  // Response monitor.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      tracker.compare_response(rsp_if.data, rsp_if.status);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("** fisher_yates_shuffle_engine: FAILED **");
      $finish;
    end
  end

  // Drive one command beat, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_cmd(input logic [1:0] op, input logic [6:0] idx,
                          input logic [DataW-1:0] val, input logic [7:0] cnt,
                          input logic [31:0] sd);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.index  <= idx;
    cmd_if.value  <= val;
    cmd_if.count  <= cnt;
    cmd_if.seed   <= sd;
    do @(posedge clk_i); while (!cmd_if.ready);
    tracker.apply_command(op, idx, val, cnt, sd);
    if (op != OpUnused) items_sent++;
  endtask

  // Fields that a command does not use carry random values.
  task automatic write_elem(input int idx, input logic [DataW-1:0] val);
    send_cmd(OpWrite, 7'(idx), val, 8'($urandom), $urandom);
  endtask

  task automatic read_elem(input int idx);
    send_cmd(OpRead, 7'(idx), 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic shuffle_elems(input int cnt, input logic [31:0] sd);
    send_cmd(OpShuffle, 7'($urandom), 8'($urandom), 8'(cnt), sd);
  endtask

  // Read back some element that already holds a written value, or write one while none is written.
  task automatic read_written();
    int idx;
    idx = tracker.pick_written();
    if (idx < 0) write_elem($urandom_range(0, MaxElements - 1), 8'($urandom));
    else read_elem(idx);
  endtask

  // One random step: mostly fill-shuffle-verify sequences and single commands.
  task automatic random_step();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, MaxElements)
                                       : $urandom_range(2, 16);
      for (int k = 0; k < n; k++) write_elem(k, 8'($urandom));
      shuffle_elems(n, $urandom);
      for (int k = 0; k < n; k++) read_elem(k);
    end else if (r < 45) begin
      write_elem($urandom_range(0, MaxElements - 1), 8'($urandom));
    end else if (r < 75) begin
      read_written();
    end else if (r < 92) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MaxElements) : $urandom_range(0, 24);
      shuffle_elems(n, $urandom);
    end else if (r < 97) begin
      shuffle_elems($urandom_range(MaxElements + 1, 255), $urandom);
    end else begin
      send_cmd(OpUnused, 7'($urandom), 8'($urandom), 8'($urandom), $urandom);
    end
  endtask

  // Main sequence.
  initial begin
    tracker       = new();
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    items_sent    = 0;
    cycles        = 0;
    cmd_if.valid  = 1'b0;
    cmd_if.opcode = OpWrite;
    cmd_if.index  = '0;
    cmd_if.value  = '0;
    cmd_if.count  = '0;
    cmd_if.seed   = '0;
    rst_ni        = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, short counts, counts out of range, the unused opcode.
    write_elem(0, 8'h00);
    write_elem(MaxElements - 1, 8'hFF);
    write_elem(1, 8'hA5);
    write_elem(2, 8'h5A);
    read_elem(0);
    read_elem(MaxElements - 1);
    shuffle_elems(0, 32'h0000_0000);
    shuffle_elems(1, 32'hFFFF_FFFF);
    shuffle_elems(2, 32'h1234_5678);
    read_elem(0);
    read_elem(1);
    shuffle_elems(3, 32'h0000_0000);
    read_elem(2);
    shuffle_elems(MaxElements + 1, $urandom);
    shuffle_elems(255, 32'hFFFF_FFFF);
    send_cmd(OpUnused, 7'h7F, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    write_elem(64, 8'h80);
    shuffle_elems(MaxElements, 32'hFFFF_FFFF);
    repeat (4) read_written();

    // Random part in four pressure phases.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 77; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 77; end
        default: begin src_idle_pct = 38; dst_stall_pct = 38; end
      endcase
      while (items_sent < (p + 1) * PhaseItems) random_step();
    end

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("** fisher_yates_shuffle_engine: PASSED **");
    end else begin
      $display("** fisher_yates_shuffle_engine: FAILED **");
    end
    $finish;
  end

endmodule
